/* src/mic_pkg.sv */
// ----------------------------------------------------------------------------
// mic_pkg : shared types and constants for the 3x3 adjugate inverse
// Request types, work entries between front and back, cofactor index table.
// ----------------------------------------------------------------------------
package mic_pkg;

  localparam int DET_W  = 100;  // determinant, 48 fraction bits, |D| < 2^97
  localparam int NUM_W  = 100;  // divider numerator
  localparam int DEN_W  = 100;  // divider denominator (2|D|)
  localparam int REM_W  = 132;  // remainder compared with den << 32
  localparam int QBITS  = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [31:0] in_r0c0;
    logic signed [31:0] in_r0c1;
    logic signed [31:0] in_r0c2;
    logic signed [31:0] in_r1c0;
    logic signed [31:0] in_r1c1;
    logic signed [31:0] in_r1c2;
    logic signed [31:0] in_r2c0;
    logic signed [31:0] in_r2c1;
    logic signed [31:0] in_r2c2;
  } mic_in_t;

  typedef struct packed {
    logic signed [31:0] out_r0c0;
    logic signed [31:0] out_r0c1;
    logic signed [31:0] out_r0c2;
    logic signed [31:0] out_r1c0;
    logic signed [31:0] out_r1c1;
    logic signed [31:0] out_r1c2;
    logic signed [31:0] out_r2c0;
    logic signed [31:0] out_r2c1;
    logic signed [31:0] out_r2c2;
    logic               inverted_ok;
  } mic_out_t;

  // one element's division job; for a singular request num holds the echo
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             neg;
  } mic_lane_t;

  typedef struct packed {
    mic_lane_t [8:0]  lane;
    logic [DEN_W-1:0] den;
    logic             ok;
  } mic_work_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   count;
  } mic_fifo_st_t;

  // cofactor i = m[e0]*m[e1] - m[e2]*m[e3]
  localparam logic [3:0] COF_IDX [0:8][0:3] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd6, 4'd5, 4'd8, 4'd3},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

/* src/mic_front.sv */
// ----------------------------------------------------------------------------
// mic_front : cofactors, determinant and singularity test
// Five-stage pipeline; the last stage builds the divider work entry.
// ----------------------------------------------------------------------------
module mic_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  mic_pkg::mic_in_t matrix,
  input  logic [30:0]      tol,
  output logic             wr,
  output mic_pkg::mic_work_t wdata,
  input  logic             q_full
);
  import mic_pkg::*;

  logic [5:1] v;
  logic adv;

  logic signed [31:0] m1 [0:8];
  logic signed [31:0] m2 [0:8];
  logic signed [31:0] m3 [0:8];
  logic signed [31:0] m4 [0:8];
  logic signed [31:0] m5 [0:8];
  logic signed [63:0] prod [0:17];
  logic signed [63:0] adj3 [0:8];
  logic signed [63:0] adj4 [0:8];
  logic signed [64:0] plo [0:2];
  logic signed [63:0] phi [0:2];
  logic signed [DET_W-1:0] det;
  logic [63:0] cm [0:8];
  logic [8:0]  cneg;
  logic signed [31:0] m_in [0:8];

  logic signed [DET_W-1:0] det_next;
  logic [DET_W-1:0] dmag;
  logic dneg, singular;

  assign adv  = !v[5] || !q_full;
  assign full = !adv;
  assign wr   = v[5] && !q_full;

  always_comb begin
    m_in[0] = matrix.in_r0c0; m_in[1] = matrix.in_r0c1; m_in[2] = matrix.in_r0c2;
    m_in[3] = matrix.in_r1c0; m_in[4] = matrix.in_r1c1; m_in[5] = matrix.in_r1c2;
    m_in[6] = matrix.in_r2c0; m_in[7] = matrix.in_r2c1; m_in[8] = matrix.in_r2c2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:1], push};
    end
  end

  always_comb begin
    det_next = '0;
    for (int j = 0; j < 3; j++) begin
      det_next = det_next + ({{(DET_W-64){phi[j][63]}}, phi[j]} <<< 32)
                          + {{(DET_W-65){plo[j][64]}}, plo[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        m1[i] <= m_in[i];
        m2[i] <= m1[i];
        m3[i] <= m2[i];
        m4[i] <= m3[i];
        m5[i] <= m4[i];
        prod[2*i]   <= m1[COF_IDX[i][0]] * m1[COF_IDX[i][1]];
        prod[2*i+1] <= m1[COF_IDX[i][2]] * m1[COF_IDX[i][3]];
        adj3[i] <= prod[2*i] - prod[2*i+1];
        adj4[i] <= adj3[i];
        cm[i]   <= adj4[i][63] ? 64'(-adj4[i]) : 64'(adj4[i]);
        cneg[i] <= adj4[i][63];
      end
      // first column times first adjugate row, split into 32-bit halves
      for (int j = 0; j < 3; j++) begin
        plo[j] <= m3[3*j] * $signed({1'b0, adj3[j][31:0]});
        phi[j] <= m3[3*j] * $signed(adj3[j][63:32]);
      end
      det <= det_next;
    end
  end

  always_comb begin
    dneg     = det[DET_W-1];
    dmag     = dneg ? DET_W'(-det) : DET_W'(det);
    singular = (dmag == '0) || (dmag < (DET_W'(tol) << 32));
    wdata.ok  = !singular;
    wdata.den = DEN_W'(dmag << 1);
    for (int i = 0; i < 9; i++) begin
      if (singular) begin
        wdata.lane[i].num = NUM_W'(unsigned'(m5[i]));
      end else begin
        wdata.lane[i].num = (NUM_W'(cm[i]) << 33) + NUM_W'(dmag);
      end
      wdata.lane[i].neg = cneg[i] ^ dneg;
    end
  end

endmodule

/* src/mic_fifo.sv */
// ----------------------------------------------------------------------------
// mic_fifo : short work queue between front and back
// Register array, one write and one read per cycle.
// ----------------------------------------------------------------------------
module mic_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  mic_pkg::mic_work_t   wdata,
  input  logic                 rd,
  output mic_pkg::mic_work_t   rdata,
  output mic_pkg::mic_fifo_st_t status
);
  import mic_pkg::*;

  mic_work_t mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign rdata         = mem[rptr];
  assign status.count  = count;
  assign status.full   = (count == (QPTR_W+1)'(QDEPTH));
  assign status.empty  = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

endmodule

/* src/mic_back.sv */
// ----------------------------------------------------------------------------
// mic_back : pipelined restoring divider, nine lanes, and result buffer
// One overflow stage, one stage per quotient bit, two-entry output buffer.
// ----------------------------------------------------------------------------
module mic_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               rd,
  input  mic_pkg::mic_work_t rdata,
  output logic               empty,
  input  logic               pop,
  output mic_pkg::mic_out_t  result
);
  import mic_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] r;
    logic [QBITS-1:0] q;
    logic             sat;
    logic             neg;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t [8:0]   lane;
    logic [DEN_W-1:0] den;
    logic             ok;
  } dv_stage_t;

  dv_stage_t stg  [0:QBITS];
  dv_stage_t nxt  [0:QBITS-1];
  dv_stage_t ld;
  logic [QBITS:0] bv;
  logic adv;

  mic_out_t obuf [0:1];
  mic_out_t fin;
  logic [1:0] ocnt;
  logic       ordp, owrp;
  logic       opush, opop;
  logic [31:0] res [0:8];

  assign adv   = !bv[QBITS] || (ocnt != 2'd2);
  assign rd    = !q_empty && adv;
  assign opush = bv[QBITS] && (ocnt != 2'd2);
  assign empty = (ocnt == 2'd0);
  assign opop  = pop && !empty;
  assign result = obuf[ordp];

  // overflow: quotient of 2^32 or more saturates either way
  always_comb begin
    ld.den = rdata.den;
    ld.ok  = rdata.ok;
    for (int i = 0; i < 9; i++) begin
      ld.lane[i].r   = REM_W'(rdata.lane[i].num);
      ld.lane[i].q   = '0;
      ld.lane[i].neg = rdata.lane[i].neg;
      ld.lane[i].sat = rdata.ok &&
                       (REM_W'(rdata.lane[i].num) >= (REM_W'(rdata.den) << QBITS));
    end
  end

  always_comb begin
    logic [REM_W-1:0] dsh;
    for (int k = 0; k < QBITS; k++) begin
      nxt[k] = stg[k];
      dsh = REM_W'(stg[k].den) << (QBITS-1-k);
      for (int i = 0; i < 9; i++) begin
        if (stg[k].ok && !stg[k].lane[i].sat && (stg[k].lane[i].r >= dsh)) begin
          nxt[k].lane[i].r = stg[k].lane[i].r - dsh;
          nxt[k].lane[i].q[QBITS-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (adv) begin
      bv <= {bv[QBITS-1:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= ld;
      for (int k = 0; k < QBITS; k++) stg[k+1] <= nxt[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (!stg[QBITS].ok) begin
        res[i] = stg[QBITS].lane[i].r[31:0];
      end else if (stg[QBITS].lane[i].neg) begin
        res[i] = (stg[QBITS].lane[i].sat || stg[QBITS].lane[i].q > SAT_NEG) ?
                 SAT_NEG : 32'(-stg[QBITS].lane[i].q);
      end else begin
        res[i] = (stg[QBITS].lane[i].sat || stg[QBITS].lane[i].q[31]) ?
                 SAT_POS : stg[QBITS].lane[i].q;
      end
    end
    fin.out_r0c0 = res[0]; fin.out_r0c1 = res[1]; fin.out_r0c2 = res[2];
    fin.out_r1c0 = res[3]; fin.out_r1c1 = res[4]; fin.out_r1c2 = res[5];
    fin.out_r2c0 = res[6]; fin.out_r2c1 = res[7]; fin.out_r2c2 = res[8];
    fin.inverted_ok = stg[QBITS].ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
      ordp <= 1'b0;
      owrp <= 1'b0;
    end else begin
      if (opush) owrp <= !owrp;
      if (opop)  ordp <= !ordp;
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) obuf[owrp] <= fin;
  end

endmodule

/* src/matrix3x3_inverse_cofactor.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse_cofactor : 3x3 Q16.16 inverse by adjugate
// Front pipeline, work queue, pipelined divider and result buffer.
// ----------------------------------------------------------------------------
// Accepts one matrix per cycle and returns one result per request, in order.
// From push to visible result a request passes five front stages (input
// register, products, cofactors, split determinant products, determinant,
// whose singularity test writes the queue), the work queue, 33 divider stages
// (overflow check plus one per quotient bit) and the output buffer.
// Throughput is one request per cycle while pop keeps up; the queue and the
// two-entry output buffer let either side stall without losing requests. A
// singular matrix (|det| below the tolerance, or zero) is echoed with
// inverted_ok low. cfg_ready is always high.
module matrix3x3_inverse_cofactor (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mic_pkg::mic_in_t  matrix,
  output logic              empty,
  input  logic              pop,
  output mic_pkg::mic_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [30:0]       cfg_data
);
  import mic_pkg::*;

  logic [30:0]  tol;
  logic         q_wr, q_rd;
  mic_work_t    q_wdata, q_rdata;
  mic_fifo_st_t q_st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 31'd1;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  mic_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .matrix (matrix),
    .tol    (tol),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .q_full (q_st.full)
  );

  mic_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .rd     (q_rd),
    .rdata  (q_rdata),
    .status (q_st)
  );

  mic_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_st.empty),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_st.count <= (QPTR_W+1)'(QDEPTH))
    else $error("work queue count out of range");

  a_q_nowrap: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> (!q_st.full || q_rd))
    else $error("front wrote a full work queue");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not clear after reset");

endmodule
